### rtl/tsl_pkg.sv
package tsl_pkg;

	typedef struct packed {
		logic [7:0] char_code;
		logic       is_final;
	} tsl_in_t;

	typedef struct packed {
		logic [1:0]  token_kind;
		logic [4:0]  symbol_code;
		logic [1:0]  error_code;
		logic [7:0]  token_length;
		logic [15:0] line_number;
		logic        last_of_run;
	} tsl_out_t;

	// up to two results from one scanned byte
	typedef struct packed {
		logic [1:0] count;
		tsl_out_t   first;
		tsl_out_t   second;
	} tsl_push_t;

	// token closed or emitted by one step, line number added later
	typedef struct packed {
		logic       hit;
		logic [1:0] kind;
		logic [4:0] sym;
		logic [1:0] err;
		logic [7:0] len;
	} tsl_emit_t;

	typedef struct packed {
		logic hit;
		logic [4:0] code;
	} tsl_sym_t;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_ZERO,
		MODE_INT,
		MODE_DOT,
		MODE_FRAC,
		MODE_WORD,
		MODE_PEND
	} mode_t;

	typedef enum logic [1:0] {
		OP_LT,
		OP_GT,
		OP_COLON
	} op_t;

	localparam logic [1:0] KIND_NUM  = 2'd0;
	localparam logic [1:0] KIND_WORD = 2'd1;
	localparam logic [1:0] KIND_SYM  = 2'd2;
	localparam logic [1:0] KIND_ERR  = 2'd3;

	localparam logic [1:0] ERR_NUM     = 2'd0;
	localparam logic [1:0] ERR_SYM     = 2'd1;
	localparam logic [1:0] ERR_WORD    = 2'd2;
	localparam logic [1:0] ERR_ILLEGAL = 2'd3;

	localparam logic [4:0] SYM_LT     = 5'd13;
	localparam logic [4:0] SYM_LE     = 5'd14;
	localparam logic [4:0] SYM_GT     = 5'd15;
	localparam logic [4:0] SYM_GE     = 5'd16;
	localparam logic [4:0] SYM_ASSIGN = 5'd17;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_UPA   = 8'h41;
	localparam logic [7:0] CH_UPZ   = 8'h5A;
	localparam logic [7:0] CH_US    = 8'h5F;
	localparam logic [7:0] CH_LOA   = 8'h61;
	localparam logic [7:0] CH_LOZ   = 8'h7A;

	localparam int QUEUE_DEPTH = 4;

	function automatic logic is_blank(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR;
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic is_letter(logic [7:0] c);
		return (c >= CH_UPA && c <= CH_UPZ) || (c >= CH_LOA && c <= CH_LOZ);
	endfunction

	function automatic tsl_sym_t single_code(logic [7:0] c);
		tsl_sym_t s;
		s.hit = 1'b1;
		case (c)
			8'h2C: s.code = 5'd0;
			8'h2E: s.code = 5'd1;
			8'h3B: s.code = 5'd2;
			8'h3F: s.code = 5'd3;
			8'h21: s.code = 5'd4;
			8'h23: s.code = 5'd5;
			8'h28: s.code = 5'd6;
			8'h29: s.code = 5'd7;
			8'h2A: s.code = 5'd8;
			8'h2F: s.code = 5'd9;
			8'h2B: s.code = 5'd10;
			8'h2D: s.code = 5'd11;
			8'h3D: s.code = 5'd12;
			8'h3C: s.code = SYM_LT;
			8'h3E: s.code = SYM_GT;
			8'h3A: s.code = SYM_ASSIGN;
			default: begin
				s.hit  = 1'b0;
				s.code = 5'd0;
			end
		endcase
		return s;
	endfunction

	function automatic logic is_delim(logic [7:0] c);
		tsl_sym_t s;
		s = single_code(c);
		return is_blank(c) || c == CH_NL || (s.hit && c != CH_DOT);
	endfunction

endpackage

### rtl/tsl_scan.sv
module tsl_scan #(
	parameter int LW  = 8,
	parameter int LNW = 16,
	parameter int MAX_TOKEN_LENGTH = 255,
	parameter int MAX_LINE = 65535
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  tsl_pkg::tsl_in_t   item,
	input  logic               room,
	output tsl_pkg::tsl_push_t push
);

	logic             valid_s1;
	tsl_pkg::tsl_in_t item_s1;
	logic             fire;

	tsl_pkg::mode_t   mode_q, m;
	logic             ok_q, ok;
	logic [LW-1:0]    len_q, len;
	logic [LNW-1:0]   line_q, ln;
	tsl_pkg::op_t     op_q, op;

	logic [7:0]         c;
	logic [1:0]         n;
	tsl_pkg::tsl_out_t  res [2];
	tsl_pkg::tsl_emit_t e;
	tsl_pkg::tsl_sym_t  sc;
	logic               do_close;

	function automatic logic [LW-1:0] len_inc(logic [LW-1:0] v);
		return (v == LW'(MAX_TOKEN_LENGTH)) ? v : v + LW'(1);
	endfunction

	function automatic tsl_pkg::tsl_emit_t close_tok(tsl_pkg::mode_t cm, logic cok,
			logic [LW-1:0] clen, tsl_pkg::op_t cop);
		tsl_pkg::tsl_emit_t r;
		r = '0;
		r.len = 8'(clen);
		case (cm)
			tsl_pkg::MODE_ZERO, tsl_pkg::MODE_INT, tsl_pkg::MODE_DOT, tsl_pkg::MODE_FRAC: begin
				r.hit = 1'b1;
				if (cok && cm != tsl_pkg::MODE_DOT) begin
					r.kind = tsl_pkg::KIND_NUM;
				end else begin
					r.kind = tsl_pkg::KIND_ERR;
					r.err  = tsl_pkg::ERR_NUM;
				end
			end
			tsl_pkg::MODE_WORD: begin
				r.hit = 1'b1;
				if (cok) begin
					r.kind = tsl_pkg::KIND_WORD;
				end else begin
					r.kind = tsl_pkg::KIND_ERR;
					r.err  = tsl_pkg::ERR_WORD;
				end
			end
			tsl_pkg::MODE_PEND: begin
				r.hit = 1'b1;
				r.len = 8'd1;
				case (cop)
					tsl_pkg::OP_LT: begin
						r.kind = tsl_pkg::KIND_SYM;
						r.sym  = tsl_pkg::SYM_LT;
					end
					tsl_pkg::OP_GT: begin
						r.kind = tsl_pkg::KIND_SYM;
						r.sym  = tsl_pkg::SYM_GT;
					end
					default: begin
						r.kind = tsl_pkg::KIND_ERR;
						r.err  = tsl_pkg::ERR_SYM;
					end
				endcase
			end
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	function automatic tsl_pkg::tsl_out_t mk(tsl_pkg::tsl_emit_t me, logic [LNW-1:0] mline);
		tsl_pkg::tsl_out_t o;
		o.token_kind   = me.kind;
		o.symbol_code  = me.sym;
		o.error_code   = me.err;
		o.token_length = me.len;
		o.line_number  = 16'(mline);
		o.last_of_run  = 1'b0;
		return o;
	endfunction

	assign fire       = valid_s1 && room;
	assign item_ready = !valid_s1 || room;
	assign c          = item_s1.char_code;

	always_comb begin
		m        = mode_q;
		ok       = ok_q;
		len      = len_q;
		ln       = line_q;
		op       = op_q;
		n        = 2'd0;
		res[0]   = '0;
		res[1]   = '0;
		e        = '0;
		sc       = tsl_pkg::single_code(c);
		do_close = 1'b0;

		case (mode_q)
			tsl_pkg::MODE_ZERO, tsl_pkg::MODE_INT, tsl_pkg::MODE_DOT, tsl_pkg::MODE_FRAC: begin
				if (c == tsl_pkg::CH_DOT || !tsl_pkg::is_delim(c)) begin
					len = len_inc(len_q);
					case (mode_q)
						tsl_pkg::MODE_ZERO: begin
							if (c == tsl_pkg::CH_DOT) m = tsl_pkg::MODE_DOT;
							else ok = 1'b0;
						end
						tsl_pkg::MODE_INT: begin
							if (c == tsl_pkg::CH_DOT) m = tsl_pkg::MODE_DOT;
							else if (!tsl_pkg::is_digit(c)) ok = 1'b0;
						end
						tsl_pkg::MODE_DOT: begin
							if (tsl_pkg::is_digit(c)) m = tsl_pkg::MODE_FRAC;
							else ok = 1'b0;
						end
						default: begin
							if (!tsl_pkg::is_digit(c)) ok = 1'b0;
						end
					endcase
				end else begin
					do_close = 1'b1;
				end
			end
			tsl_pkg::MODE_WORD: begin
				if (!tsl_pkg::is_delim(c)) begin
					len = len_inc(len_q);
					if (!(tsl_pkg::is_letter(c) || tsl_pkg::is_digit(c) || c == tsl_pkg::CH_US))
						ok = 1'b0;
				end else begin
					do_close = 1'b1;
				end
			end
			tsl_pkg::MODE_PEND: begin
				if (c == tsl_pkg::CH_EQ) begin
					e      = '0;
					e.hit  = 1'b1;
					e.kind = tsl_pkg::KIND_SYM;
					e.len  = 8'd2;
					case (op_q)
						tsl_pkg::OP_LT: e.sym = tsl_pkg::SYM_LE;
						tsl_pkg::OP_GT: e.sym = tsl_pkg::SYM_GE;
						default:        e.sym = tsl_pkg::SYM_ASSIGN;
					endcase
					res[0] = mk(e, ln);
					n      = 2'd1;
					m      = tsl_pkg::MODE_IDLE;
					ok     = 1'b1;
					len    = '0;
					op     = tsl_pkg::OP_LT;
				end else begin
					do_close = 1'b1;
				end
			end
			default: ;
		endcase

		// close the open token, then treat the byte as a fresh start
		if (do_close) begin
			e = close_tok(m, ok, len, op);
			if (e.hit) begin
				res[n[0]] = mk(e, ln);
				n = n + 2'd1;
			end
			m   = tsl_pkg::MODE_IDLE;
			ok  = 1'b1;
			len = '0;
			op  = tsl_pkg::OP_LT;
		end

		if (do_close || mode_q == tsl_pkg::MODE_IDLE) begin
			ok  = 1'b1;
			len = LW'(1);
			e   = '0;
			if (tsl_pkg::is_digit(c)) begin
				m = (c == tsl_pkg::CH_ZERO) ? tsl_pkg::MODE_ZERO : tsl_pkg::MODE_INT;
			end else if (tsl_pkg::is_letter(c)) begin
				m = tsl_pkg::MODE_WORD;
			end else if (c == tsl_pkg::CH_LT || c == tsl_pkg::CH_GT || c == tsl_pkg::CH_COLON) begin
				m  = tsl_pkg::MODE_PEND;
				op = (c == tsl_pkg::CH_LT) ? tsl_pkg::OP_LT :
				     (c == tsl_pkg::CH_GT) ? tsl_pkg::OP_GT : tsl_pkg::OP_COLON;
			end else if (sc.hit) begin
				e.hit  = 1'b1;
				e.kind = tsl_pkg::KIND_SYM;
				e.sym  = sc.code;
				e.len  = 8'd1;
				len    = '0;
			end else if (tsl_pkg::is_blank(c)) begin
				len = '0;
			end else if (c == tsl_pkg::CH_NL) begin
				len = '0;
				if (ln != LNW'(MAX_LINE)) ln = ln + LNW'(1);
			end else begin
				e.hit  = 1'b1;
				e.kind = tsl_pkg::KIND_ERR;
				e.err  = tsl_pkg::ERR_ILLEGAL;
				e.len  = 8'd1;
				len    = '0;
			end
			if (e.hit) begin
				res[n[0]] = mk(e, ln);
				n = n + 2'd1;
			end
		end

		// end of stream flushes the open token and restarts the line count
		if (item_s1.is_final) begin
			e = close_tok(m, ok, len, op);
			if (e.hit) begin
				res[n[0]] = mk(e, ln);
				n = n + 2'd1;
			end
			m   = tsl_pkg::MODE_IDLE;
			ok  = 1'b1;
			len = '0;
			op  = tsl_pkg::OP_LT;
			ln  = '0;
		end

		if (n == 2'd1) res[0].last_of_run = 1'b1;
		if (n == 2'd2) res[1].last_of_run = 1'b1;

		push.count  = fire ? n : 2'd0;
		push.first  = res[0];
		push.second = res[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= tsl_pkg::MODE_IDLE;
			ok_q   <= 1'b1;
			len_q  <= '0;
			line_q <= '0;
			op_q   <= tsl_pkg::OP_LT;
		end else if (fire) begin
			mode_q <= m;
			ok_q   <= ok;
			len_q  <= len;
			line_q <= ln;
			op_q   <= op;
		end
	end

endmodule

### rtl/tsl_result_queue.sv
module tsl_result_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  tsl_pkg::tsl_push_t push,
	output logic               room,
	output logic               result_valid,
	input  logic               result_ready,
	output tsl_pkg::tsl_out_t  result
);

	localparam int PW = $clog2(tsl_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(tsl_pkg::QUEUE_DEPTH + 1);

	tsl_pkg::tsl_out_t slot_q [tsl_pkg::QUEUE_DEPTH];
	logic [PW-1:0]     wr_q, rd_q;
	logic [CW-1:0]     count_q;
	logic              pop;

	assign room         = count_q <= CW'(tsl_pkg::QUEUE_DEPTH - 2);
	assign result_valid = count_q != '0;
	assign result       = slot_q[rd_q];
	assign pop          = result_valid && result_ready;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			slot_q[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			slot_q[wr_q + PW'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PW'(push.count);
			rd_q    <= rd_q + PW'(pop);
			count_q <= count_q + CW'(push.count) - CW'(pop);
		end
	end

endmodule

### rtl/token_stream_lexer_top.sv
// token stream lexer
// item channel: one source byte per transfer (char_code, is_final); is_final
// marks the last byte of a stream, after which open tokens are flushed and
// the line count starts again at zero
// result channel: one token per transfer (kind, symbol code, error code,
// saturated length, line number); last_of_run marks the final result caused
// by a byte, and a byte causes zero, one or two results
// a byte is registered at the scan stage and its results are written to the
// queue together; a second result is offered once the first is taken
// throughput: one byte per cycle while the queue has room, set by the single
// scan stage; sustained output is one result per cycle from a 4-entry queue
// the scan stage advances while the queue has room for two results, so a
// stalled receiver holds bytes back once three results wait in the queue
// reset: asynchronous, active low; clears the scanner to idle with line 0
// and empties the queue
module token_stream_lexer_top #(
	parameter int MAX_TOKEN_LENGTH = 255,
	parameter int MAX_LINE = 65535
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  tsl_pkg::tsl_in_t  item,
	output logic              result_valid,
	input  logic              result_ready,
	output tsl_pkg::tsl_out_t result
);

	localparam int LW  = $clog2(MAX_TOKEN_LENGTH + 1);
	localparam int LNW = $clog2(MAX_LINE + 1);

	tsl_pkg::tsl_push_t push;
	logic               room;

	tsl_scan #(
		.LW               (LW),
		.LNW              (LNW),
		.MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH),
		.MAX_LINE         (MAX_LINE)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.room       (room),
		.push       (push)
	);

	tsl_result_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (room),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

### rtl/tsl_checker.sv
module tsl_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input tsl_pkg::tsl_in_t  item,
	input logic              result_valid,
	input logic              result_ready,
	input tsl_pkg::tsl_out_t result
);

	// offered byte holds until taken
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid && $stable(item))
		else $error("item changed while stalled");

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_sym_only: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.token_kind != tsl_pkg::KIND_SYM |-> result.symbol_code == 5'd0)
		else $error("symbol code on non-symbol token");

	a_err_only: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.token_kind != tsl_pkg::KIND_ERR |-> result.error_code == 2'd0)
		else $error("error code on non-error token");

	// two-character symbols are exactly the compound ones
	a_sym_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.token_kind == tsl_pkg::KIND_SYM |->
		(result.token_length == 8'd2) == (result.symbol_code == tsl_pkg::SYM_LE ||
		result.symbol_code == tsl_pkg::SYM_GE || result.symbol_code == tsl_pkg::SYM_ASSIGN))
		else $error("symbol length mismatch");

endmodule

bind token_stream_lexer_top tsl_checker u_tsl_checker (.*);
